/* rtl/core/fds_pkg.sv */
// shared types and constants for the frame delay sequencer
package fds_pkg;

  localparam int MAX_FRAMES_DEF = 64;
  localparam int TIME_BITS_DEF  = 20;

  typedef enum logic [2:0] {
    CMD_TICK        = 3'd0,
    CMD_PLAY        = 3'd1,
    CMD_STOP        = 3'd2,
    CMD_PAUSE       = 3'd3,
    CMD_RESUME      = 3'd4,
    CMD_SHOW_FIRST  = 3'd5,
    CMD_WRITE_DELAY = 3'd6,
    CMD_NONE        = 3'd7
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STEP,
    ST_SUM,
    ST_MOD,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic start;
  } mod_ctl_t;

  typedef struct packed {
    logic done;
  } mod_status_t;

endpackage

/* rtl/core/fds_mod.sv */
// iterative restoring remainder unit, one dividend bit per cycle
module fds_mod #(
  parameter int DW = fds_pkg::TIME_BITS_DEF + 1,
  parameter int VW = fds_pkg::TIME_BITS_DEF + 7
) (
  input  logic                clk,
  input  logic                rst,
  input  fds_pkg::mod_ctl_t   ctl,
  input  logic [DW-1:0]       dividend,
  input  logic [VW-1:0]       divisor,
  output fds_pkg::mod_status_t status,
  output logic [DW-1:0]       remainder
);

  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0] dvd;
  logic [VW-1:0] dvs;
  logic [VW-1:0] rem;
  logic [CW-1:0] count;
  logic          busy;
  logic          done;

  logic [VW:0]   shifted;
  logic          fits;

  always_comb begin
    shifted = {rem, dvd[DW-1]};
    fits    = shifted >= {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy  <= 1'b1;
        count <= CW'(DW);
      end else if (busy) begin
        count <= count - CW'(1);
        if (count == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      dvd <= dividend;
      dvs <= divisor;
      rem <= '0;
    end else if (busy) begin
      dvd <= {dvd[DW-2:0], 1'b0};
      if (fits) begin
        rem <= VW'(shifted - {1'b0, dvs});
      end else begin
        rem <= shifted[VW-1:0];
      end
    end
  end

  // remainder is no larger than the dividend, so the low bits hold it
  assign remainder   = rem[DW-1:0];
  assign status.done = done;

endmodule

/* rtl/core/frame_delay_sequencer.sv */
// animation frame sequencer with per-frame delays kept in a synchronous memory
//
//   channel   signals                                      handshake
//   --------  -------------------------------------------  -----------------------
//   input     command loop_enable delta_time frame_slot     in_valid / in_ready
//             delay_value
//   output    frame_index frame_changed is_playing          out_valid / out_ready
//             is_paused accepted
//   config    frame_count                                  frame_count_we, no wait
//
// one word at a time: a running tick steps through the frames that it advances, each
// step reading one delay from the memory port.
// the first wrap of a looping tick adds a pass that sums the delays and a run of the
// remainder unit; at most n further steps follow.
// reset clears the player state; the delay memory holds no reset value.
// a result waiting on out_ready holds the block before it returns to idle.
module frame_delay_sequencer #(
  parameter int MAX_FRAMES = fds_pkg::MAX_FRAMES_DEF,
  parameter int TIME_BITS  = fds_pkg::TIME_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          frame_count_we,
  input  logic [$clog2(MAX_FRAMES+1)-1:0] frame_count,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [2:0]                    command,
  input  logic                          loop_enable,
  input  logic [TIME_BITS-1:0]          delta_time,
  input  logic [$clog2(MAX_FRAMES)-1:0] frame_slot,
  input  logic [TIME_BITS-1:0]          delay_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [$clog2(MAX_FRAMES)-1:0] frame_index,
  output logic                          frame_changed,
  output logic                          is_playing,
  output logic                          is_paused,
  output logic                          accepted
);

  localparam int FB = $clog2(MAX_FRAMES);
  localparam int CB = $clog2(MAX_FRAMES + 1);
  localparam int EW = TIME_BITS + 1;
  localparam int SW = TIME_BITS + CB;

  // delay memory
  logic [TIME_BITS-1:0] mem [MAX_FRAMES];
  logic [TIME_BITS-1:0] rdata;
  logic [FB-1:0]        rd_addr;

  fds_pkg::state_t state, state_next;

  logic [CB-1:0] count_reg;
  logic [FB-1:0] cur, cur_next;
  logic [EW-1:0] elapsed, elapsed_next;
  logic          playing, playing_next;
  logic          paused, paused_next;
  logic          loop_mode, loop_mode_next;
  logic          changed, changed_next;
  logic          acc, acc_next;
  logic          wrapped, wrapped_next;
  logic [FB-1:0] sweep, sweep_next;
  logic [SW-1:0] total, total_next;
  logic          load_out;

  logic [CB-1:0]        n;
  logic [TIME_BITS-1:0] d_eff;
  logic                 accept;
  logic                 write_delay;
  fds_pkg::cmd_t        cmd;

  fds_pkg::mod_ctl_t    mod_ctl;
  fds_pkg::mod_status_t mod_status;
  logic [EW-1:0]        mod_rem;

  assign n      = (count_reg > CB'(MAX_FRAMES)) ? CB'(MAX_FRAMES) : count_reg;
  assign d_eff  = (rdata == '0) ? TIME_BITS'(1) : rdata;
  assign accept = in_valid && in_ready;
  assign cmd    = fds_pkg::cmd_t'(command);
  assign write_delay = accept && (cmd == fds_pkg::CMD_WRITE_DELAY) &&
                       ({1'b0, frame_slot} < (FB + 1)'(MAX_FRAMES));
  assign in_ready = (state == fds_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (write_delay) begin
      mem[frame_slot] <= delay_value;
    end
    rdata <= mem[rd_addr];
  end

  fds_mod #(
    .DW(EW),
    .VW(SW)
  ) u_mod (
    .clk      (clk),
    .rst      (rst),
    .ctl      (mod_ctl),
    .dividend (elapsed),
    .divisor  (total_next),
    .status   (mod_status),
    .remainder(mod_rem)
  );

  always_comb begin
    state_next     = state;
    cur_next       = cur;
    elapsed_next   = elapsed;
    playing_next   = playing;
    paused_next    = paused;
    loop_mode_next = loop_mode;
    changed_next   = changed;
    acc_next       = acc;
    wrapped_next   = wrapped;
    sweep_next     = sweep;
    total_next     = total;
    rd_addr        = cur;
    mod_ctl.start  = 1'b0;
    load_out       = 1'b0;

    unique case (state)
      fds_pkg::ST_IDLE: begin
        if (accept) begin
          changed_next = 1'b0;
          acc_next     = 1'b0;
          state_next   = fds_pkg::ST_RESULT;
          case (cmd)
            fds_pkg::CMD_TICK: begin
              if (playing && !paused && (n != '0)) begin
                if (CB'(cur) >= n) begin
                  cur_next     = '0;
                  changed_next = 1'b1;
                end
                elapsed_next = elapsed + EW'(delta_time);
                wrapped_next = 1'b0;
                rd_addr      = cur_next;
                state_next   = fds_pkg::ST_STEP;
              end
            end
            fds_pkg::CMD_PLAY: begin
              if (n != '0) begin
                loop_mode_next = loop_enable;
                cur_next       = '0;
                elapsed_next   = '0;
                playing_next   = 1'b1;
                paused_next    = 1'b0;
                changed_next   = 1'b1;
                acc_next       = 1'b1;
              end
            end
            fds_pkg::CMD_STOP: begin
              playing_next = 1'b0;
              paused_next  = 1'b0;
              cur_next     = '0;
              elapsed_next = '0;
              changed_next = (n != '0);
            end
            fds_pkg::CMD_PAUSE: begin
              if (playing) begin
                paused_next = 1'b1;
                acc_next    = 1'b1;
              end
            end
            fds_pkg::CMD_RESUME: begin
              if (playing && paused) begin
                paused_next = 1'b0;
                acc_next    = 1'b1;
              end
            end
            fds_pkg::CMD_SHOW_FIRST: begin
              if (playing) begin
                acc_next = 1'b1;
              end else if (n != '0) begin
                cur_next     = '0;
                elapsed_next = '0;
                changed_next = 1'b1;
                acc_next     = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end

      fds_pkg::ST_STEP: begin
        // rdata holds the delay of the current frame
        if (elapsed >= EW'(d_eff)) begin
          elapsed_next = elapsed - EW'(d_eff);
          if ((CB'(cur) + CB'(1)) < n) begin
            cur_next     = cur + FB'(1);
            changed_next = 1'b1;
            rd_addr      = cur_next;
          end else if (loop_mode) begin
            cur_next     = '0;
            changed_next = 1'b1;
            rd_addr      = '0;
            if (!wrapped) begin
              wrapped_next = 1'b1;
              total_next   = '0;
              sweep_next   = '0;
              state_next   = fds_pkg::ST_SUM;
            end
          end else begin
            playing_next = 1'b0;
            elapsed_next = '0;
            state_next   = fds_pkg::ST_RESULT;
          end
        end else begin
          state_next = fds_pkg::ST_RESULT;
        end
      end

      fds_pkg::ST_SUM: begin
        // one delay per cycle into the loop length
        total_next = total + SW'(d_eff);
        if ((CB'(sweep) + CB'(1)) == n) begin
          mod_ctl.start = 1'b1;
          state_next    = fds_pkg::ST_MOD;
        end else begin
          sweep_next = sweep + FB'(1);
          rd_addr    = sweep_next;
        end
      end

      fds_pkg::ST_MOD: begin
        // address stays on frame zero so its delay is ready for the next step
        if (mod_status.done) begin
          elapsed_next = mod_rem;
          state_next   = fds_pkg::ST_STEP;
        end
      end

      fds_pkg::ST_RESULT: begin
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          state_next = fds_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = fds_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= fds_pkg::ST_IDLE;
      count_reg <= '0;
      cur       <= '0;
      elapsed   <= '0;
      playing   <= 1'b0;
      paused    <= 1'b0;
      loop_mode <= 1'b0;
      wrapped   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cur       <= cur_next;
      elapsed   <= elapsed_next;
      playing   <= playing_next;
      paused    <= paused_next;
      loop_mode <= loop_mode_next;
      wrapped   <= wrapped_next;
      if (frame_count_we) begin
        count_reg <= frame_count;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    changed <= changed_next;
    acc     <= acc_next;
    sweep   <= sweep_next;
    total   <= total_next;
    if (load_out) begin
      frame_index   <= cur;
      frame_changed <= changed;
      is_playing    <= playing;
      is_paused     <= paused;
      accepted      <= acc;
    end
  end

endmodule

/* rtl/core/fds_chk.sv */
// port-level checks for the frame delay sequencer, bound to the top level
module fds_chk #(
  parameter int MAX_FRAMES = fds_pkg::MAX_FRAMES_DEF
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [$clog2(MAX_FRAMES)-1:0] frame_index,
  input logic                          frame_changed,
  input logic                          is_playing,
  input logic                          is_paused,
  input logic                          accepted
);

  // one word in flight: after an accept the input side closes
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while a word is still in work");

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(frame_index) &&
      $stable(frame_changed) && $stable(is_playing) && $stable(is_paused) &&
      $stable(accepted)))
    else $error("result changed while stalled");

  // pause only exists during playback
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!is_paused || is_playing))
    else $error("paused without playing");

  // a refresh from play or show first always lands on frame zero
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && accepted && frame_changed) |-> (frame_index == '0))
    else $error("accepted refresh not on first frame");

endmodule

bind frame_delay_sequencer fds_chk #(
  .MAX_FRAMES(MAX_FRAMES)
) u_fds_chk (.*);

/* bench/frame_delay_sequencer_check.sv */
// checker for the frame delay sequencer: tracks player state and compares every result word
module frame_delay_sequencer_check
  import fds_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        frame_count_we,
  input  logic [6:0]  frame_count,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [2:0]  command,
  input  logic        loop_enable,
  input  logic [19:0] delta_time,
  input  logic [5:0]  frame_slot,
  input  logic [19:0] delay_value,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [5:0]  frame_index,
  input  logic        frame_changed,
  input  logic        is_playing,
  input  logic        is_paused,
  input  logic        accepted,
  output int          mismatches,
  output int          pending_words
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NF = MAX_FRAMES_DEF;
  localparam int TW = TIME_BITS_DEF;

  typedef struct packed {
    logic [5:0] frame;
    logic       changed;
    logic       playing;
    logic       paused;
    logic       acc;
  } player_status_t;

  logic [6:0]      count_reg;
  logic [TW-1:0]   delay_mem [NF];
  logic [5:0]      cur;
  longint unsigned run_time;
  bit              playing, paused, looping;
  player_status_t  status_q [$];
  player_status_t  got, want;
  int              errors = 0;

  function automatic int unsigned frames_in_use();
    return (count_reg > NF) ? NF : count_reg;
  endfunction

  // a zero delay still holds the frame for one unit
  function automatic longint unsigned hold_units(int unsigned f);
    longint unsigned d;
    d = 64'(delay_mem[f]);
    return (d == 0) ? 1 : d;
  endfunction

  function automatic bit advance(input logic [TW-1:0] dt);
    int unsigned     n;
    bit              refresh;
    bit              folded;
    longint unsigned span;
    n = frames_in_use();
    refresh = 1'b0;
    folded = 1'b0;
    if (!playing || paused || n == 0) return 1'b0;
    if (cur >= n) begin
      cur = '0;
      refresh = 1'b1;
    end
    run_time += 64'(dt);
    while (run_time >= hold_units(32'(cur))) begin
      run_time -= hold_units(32'(cur));
      if (cur + 1 < n) begin
        cur++;
        refresh = 1'b1;
      end else if (looping) begin
        cur = '0;
        refresh = 1'b1;
        // drop whole passes through the animation on the first wrap only
        if (!folded) begin
          span = 0;
          for (int i = 0; i < n; i++) span += hold_units(i);
          run_time %= span;
          folded = 1'b1;
        end
      end else begin
        playing = 1'b0;
        run_time = 0;
        break;
      end
    end
    return refresh;
  endfunction

  function automatic player_status_t next_status(cmd_t op, logic lp, logic [TW-1:0] dt,
                                                 logic [5:0] slot, logic [TW-1:0] dv);
    player_status_t r;
    int unsigned    n;
    n = frames_in_use();
    r = '0;
    case (op)
      CMD_TICK: r.changed = advance(dt);
      CMD_PLAY: if (n != 0) begin
        looping = lp;
        cur = '0;
        run_time = 0;
        playing = 1'b1;
        paused = 1'b0;
        r.changed = 1'b1;
        r.acc = 1'b1;
      end
      CMD_STOP: begin
        playing = 1'b0;
        paused = 1'b0;
        cur = '0;
        run_time = 0;
        r.changed = (n != 0);
      end
      CMD_PAUSE: if (playing) begin
        paused = 1'b1;
        r.acc = 1'b1;
      end
      CMD_RESUME: if (playing && paused) begin
        paused = 1'b0;
        r.acc = 1'b1;
      end
      CMD_SHOW_FIRST: if (playing) begin
        r.acc = 1'b1;
      end else if (n != 0) begin
        cur = '0;
        run_time = 0;
        r.changed = 1'b1;
        r.acc = 1'b1;
      end
      CMD_WRITE_DELAY: delay_mem[slot] = dv;
      default: ;
    endcase
    r.frame = cur;
    r.playing = playing;
    r.paused = paused;
    return r;
  endfunction

  task automatic check_field(input string label, input logic [31:0] want_v, got_v);
    if (got_v !== want_v) begin
      $display("%0t ns: %s expected %0d, got %0d", $time, label, want_v, got_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      count_reg = '0;
      cur = '0;
      run_time = 0;
      playing = 1'b0;
      paused = 1'b0;
      looping = 1'b0;
      status_q.delete();
    end else begin
      if (frame_count_we) count_reg = frame_count;
      if (in_valid && in_ready)
        status_q.push_back(next_status(cmd_t'(command), loop_enable, delta_time,
                                       frame_slot, delay_value));
      if (out_valid && out_ready) begin
        got = '{frame: frame_index, changed: frame_changed, playing: is_playing,
                paused: is_paused, acc: accepted};
        if (status_q.size() == 0) begin
          $display("%0t ns: result word with none outstanding, expected nothing, got frame %0d",
                   $time, frame_index);
          errors++;
        end else begin
          want = status_q.pop_front();
          check_field("frame_index", 32'(want.frame), 32'(got.frame));
          check_field("frame_changed", 32'(want.changed), 32'(got.changed));
          check_field("is_playing", 32'(want.playing), 32'(got.playing));
          check_field("is_paused", 32'(want.paused), 32'(got.paused));
          check_field("accepted", 32'(want.acc), 32'(got.acc));
        end
      end
    end
    mismatches <= errors;
    pending_words <= status_q.size();
  end

endmodule

/* bench/frame_delay_sequencer_test.sv */
// top of the frame delay sequencer bench: clock, reset, command stimulus and verdict
module frame_delay_sequencer_test;
  import fds_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 2000;
  localparam int WORDS_PER_PHASE = 75;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        frame_count_we = 1'b0;
  logic [6:0]  frame_count = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  command = CMD_NONE;
  logic        loop_enable = 1'b0;
  logic [19:0] delta_time = '0;
  logic [5:0]  frame_slot = '0;
  logic [19:0] delay_value = '0;
  logic        out_valid;
  logic        out_ready = 1'b1;
  logic [5:0]  frame_index;
  logic        frame_changed;
  logic        is_playing;
  logic        is_paused;
  logic        accepted;
  int          mismatches;
  int          pending_words;

  bit          idle_on = 1'b1;
  bit          slot_written [64];
  int          active_frames = 0;

  frame_delay_sequencer DUT (.*);
  frame_delay_sequencer_check CHECK (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // lowest delay entry below the frame count that has no value yet, or -1
  function automatic int first_missing();
    for (int i = 0; i < active_frames; i++)
      if (!slot_written[i]) return i;
    return -1;
  endfunction

  task automatic put_word(input cmd_t op, input logic lp, input logic [19:0] dt,
                          input logic [5:0] slot, input logic [19:0] dv);
    int gap_slot;
    gap_slot = first_missing();
    // playback may read any delay below the frame count, so fill those first
    if (op != CMD_WRITE_DELAY && gap_slot >= 0) begin
      op = CMD_WRITE_DELAY;
      slot = 6'(gap_slot);
      dv = 20'($urandom_range(0, 12));
    end
    if (op == CMD_WRITE_DELAY) slot_written[slot] = 1'b1;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= op;
    loop_enable <= lp;
    delta_time <= dt;
    frame_slot <= slot;
    delay_value <= dv;
    do @(posedge clk); while (!in_ready);
  endtask

  // register writes only once every result word has come back
  task automatic set_frame_count(input logic [6:0] value);
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_words != 0);
    frame_count_we <= 1'b1;
    frame_count <= value;
    @(posedge clk);
    frame_count_we <= 1'b0;
    active_frames = (value > 64) ? 64 : value;
  endtask

  initial begin : sink_pacing
    forever begin
      @(posedge clk);
      if (idle_on && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int stalled;
    stalled = 0;
    while (stalled < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) stalled = 0;
      else stalled++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus
    logic [6:0]  phase_counts [10];
    int unsigned pick;
    cmd_t        op;
    logic [19:0] dt, dv;
    logic [5:0]  slot;
    phase_counts = '{7'd2, 7'd5, 7'd64, 7'd1, 7'd127, 7'd0, 7'd3, 7'd65, 7'd8, 7'd4};

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // no animation loaded: everything fails or does nothing
    put_word(CMD_TICK, 1'b0, 20'd9, '0, '0);
    put_word(CMD_PLAY, 1'b1, '0, '0, '0);
    put_word(CMD_SHOW_FIRST, 1'b0, '0, '0, '0);
    put_word(CMD_PAUSE, 1'b0, '0, '0, '0);
    put_word(CMD_RESUME, 1'b0, '0, '0, '0);
    put_word(CMD_STOP, 1'b0, '0, '0, '0);
    put_word(CMD_NONE, 1'b1, '1, '1, '1);

    set_frame_count(7'd3);
    put_word(CMD_WRITE_DELAY, 1'b0, '0, 6'd0, 20'd0);
    put_word(CMD_WRITE_DELAY, 1'b0, '0, 6'd1, '1);
    put_word(CMD_WRITE_DELAY, 1'b0, '0, 6'd2, 20'd5);
    put_word(CMD_WRITE_DELAY, 1'b0, '0, 6'd63, 20'd7);
    put_word(CMD_TICK, 1'b0, 20'd4, '0, '0);
    put_word(CMD_SHOW_FIRST, 1'b0, '0, '0, '0);
    put_word(CMD_PLAY, 1'b0, '0, '0, '0);
    put_word(CMD_TICK, 1'b0, 20'd0, '0, '0);
    put_word(CMD_TICK, 1'b0, 20'd1, '0, '0);
    put_word(CMD_PAUSE, 1'b0, '0, '0, '0);
    put_word(CMD_TICK, 1'b0, 20'd3, '0, '0);
    put_word(CMD_PAUSE, 1'b0, '0, '0, '0);
    put_word(CMD_RESUME, 1'b0, '0, '0, '0);
    put_word(CMD_RESUME, 1'b0, '0, '0, '0);
    put_word(CMD_TICK, 1'b0, '1, '0, '0);
    // last frame without looping stops the player
    put_word(CMD_TICK, 1'b0, 20'd5, '0, '0);
    put_word(CMD_PLAY, 1'b1, '0, '0, '0);
    put_word(CMD_TICK, 1'b0, '1, '0, '0);
    put_word(CMD_TICK, 1'b0, '1, '0, '0);
    put_word(CMD_SHOW_FIRST, 1'b0, '0, '0, '0);
    // shrink the animation under the current frame
    set_frame_count(7'd1);
    put_word(CMD_TICK, 1'b0, 20'd0, '0, '0);

    for (int ph = 0; ph < 10; ph++) begin
      idle_on = (ph % 3 != 2) && (ph < 8);
      set_frame_count(phase_counts[ph]);
      for (int k = 0; k < WORDS_PER_PHASE; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 45) op = CMD_TICK;
        else if (pick < 57) op = CMD_PLAY;
        else if (pick < 62) op = CMD_STOP;
        else if (pick < 69) op = CMD_PAUSE;
        else if (pick < 76) op = CMD_RESUME;
        else if (pick < 82) op = CMD_SHOW_FIRST;
        else if (pick < 96) op = CMD_WRITE_DELAY;
        else op = CMD_NONE;
        dt = 20'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 20'hFFFFF)
                                              : $urandom_range(0, 24));
        dv = 20'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 20'hFFFFF)
                                              : $urandom_range(0, 12));
        slot = 6'($urandom_range(0, 1) ? $urandom_range(0, 63) : $urandom_range(0, 7));
        put_word(op, 1'($urandom_range(0, 1)), dt, slot, dv);
      end
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (pending_words != 0);
    repeat (16) @(posedge clk);
    if (mismatches == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/fds_pkg.sv
rtl/core/fds_mod.sv
rtl/core/frame_delay_sequencer.sv
rtl/core/fds_chk.sv
bench/frame_delay_sequencer_check.sv
bench/frame_delay_sequencer_test.sv
